// ===== hdl/fla_pkg.sv =====
// Shared types and constants of the free list heap allocator.
`timescale 1ns / 1ps
package fla_pkg;

    localparam int HEAP_BYTES = 4096;
    localparam int MEM_AW     = $clog2(HEAP_BYTES);
    localparam int STEP_W     = $clog2(HEAP_BYTES + 1);
    localparam int ADDR_W     = 36;
    localparam int HSIZE_W    = 13;

    typedef logic signed [ADDR_W-1:0] t_addr;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_FORMAT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic [HSIZE_W-1:0] HSIZE_RESET = 13'd4096;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] req_size;
        logic [15:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload_offset;
    } t_rsp;

    typedef enum logic [1:0] {
        MEM_RD32,
        MEM_WR32,
        MEM_SET,
        MEM_CLR
    } t_mem_op;

    typedef struct packed {
        logic        valid;
        t_mem_op     op;
        t_addr       addr;
        logic [31:0] data;
        logic        used;
    } t_mem_cmd;

    typedef struct packed {
        logic        done;
        logic        clearing;
        logic [31:0] rdata;
    } t_mem_sts;

    typedef enum logic [6:0] {
        S_CLR, S_IDLE,
        S_FMT0, S_FMT1, S_FMT2, S_FMT3, S_FMT4, S_FMT5, S_FMT6,
        S_A_HEAD, S_A_OLD, S_A_NXT, S_A_PRV,
        S_W_LINK, S_W_SIZE, S_G_NXT, S_G_PRV, S_G0,
        S_GS_HDR, S_GS_FTR, S_GS_RHDR, S_GS_RNXT, S_GS_RPRV, S_GS_HEAD1,
        S_GS_TAIL, S_GS_NLNK, S_GS_PLNK,
        S_GW_SET, S_GW_HEAD, S_GW_NCLR, S_GW_NLNK, S_GW_PLNK, S_GW_SELF, S_GW_SETF,
        S_F_HDR, S_F_FTR, S_F_CLR, S_F_SIZE, S_F_FIRST,
        S_FE_CLR, S_FE_HEAD, S_FE_N, S_FE_P,
        S_FB_RD, S_FB_CLR, S_FB_FL, S_FB_N, S_FB_P, S_FB_HEAD,
        S_FL_RD, S_FR_RD,
        S_PH_N, S_PH_FL, S_PH_P, S_PH_HEAD, S_PH_CLR,
        S_MR_CLR, S_MR_RSZ, S_MR_NXT, S_MR_PRV, S_MR_HDR, S_MR_N, S_MR_NLNK,
        S_MR_P, S_MR_PLNK, S_MR_FTR,
        S_B_CLR, S_B_LSZ, S_B_RSZ, S_B_HDR, S_B_NXT, S_B_PRV, S_B_NLNK,
        S_B_PLNK, S_B_FTR
    } t_state;

endpackage

// ===== hdl/free_list_heap_allocator_core.sv =====
// Top level of the free list heap allocator: controller plus tag datapath.
//
// Usage: drive i_req and raise start; the request is taken at a clock edge
// with start high and busy low. op 0 allocates req_size bytes (first fit,
// split when 16 or more bytes remain), op 1 frees free_offset with boundary
// tag merge, op 2 reformats the heap from the heap_size register.
// One result per request appears on o_rsp for exactly one cycle with o_done
// high; there is no backpressure, the receiver must take it then.
// Every tag access is a byte-serial pass over the single store port: a
// 32-bit read or write steps through four bytes, a bit update reads and
// rewrites one byte. A first-fit walk reads the link and size tags of
// each visited free block in turn.
// busy drops in the cycle of o_done, so the next request may follow at once.
// heap_size is written on i_cfg_valid (always ready); the user must write it
// only while idle, as the block itself does not enforce this.
// Reset: a clearing pass zeroes all 4096 bytes one per cycle, then the heap
// is formatted as one free block of 4088 bytes; busy stays high throughout
// and no result is produced for it.
`timescale 1ns / 1ps
module free_list_heap_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fla_pkg::t_req               i_req,
    output logic                        o_done,
    output fla_pkg::t_rsp               o_rsp,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fla_pkg::HSIZE_W-1:0] i_cfg_data
);
    import fla_pkg::*;

    t_mem_cmd mem_cmd;
    t_mem_sts mem_sts;

    fla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (mem_cmd),
        .i_sts       (mem_sts)
    );

    fla_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mem_cmd),
        .o_sts   (mem_sts)
    );

endmodule

// ===== hdl/fla_dp.sv =====
// Datapath: heap byte store with 32-bit tag read/write and bit update engine.
`timescale 1ns / 1ps
module fla_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fla_pkg::t_mem_cmd i_cmd,
    output fla_pkg::t_mem_sts o_sts
);
    import fla_pkg::*;

    localparam t_addr HEAP_A = t_addr'(HEAP_BYTES);

    logic [7:0]        mem [HEAP_BYTES];
    logic [7:0]        r_q;

    logic              r_busy;
    logic              r_done;
    logic              r_clearing;
    logic [MEM_AW-1:0] r_clr_idx;
    t_mem_op           r_op;
    t_addr             r_addr;
    logic [31:0]       r_data;
    logic              r_used;
    logic [2:0]        r_k;
    logic              r_rv;
    logic [31:0]       r_acc;

    t_addr             byte_addr;
    logic              inr;
    logic [MEM_AW-1:0] idx;
    logic              we;
    logic [MEM_AW-1:0] widx;
    logic [7:0]        wdat;
    logic [7:0]        wr_byte;

    // bit updates stay on one byte, word ops step through four
    assign byte_addr = r_addr + ((r_op == MEM_RD32 || r_op == MEM_WR32) ?
                                 t_addr'(r_k) : t_addr'(0));
    assign inr       = (byte_addr >= t_addr'(0)) && (byte_addr < HEAP_A);
    assign idx       = byte_addr[MEM_AW-1:0];

    always_comb begin
        case (r_k[1:0])
            2'd0:    wr_byte = r_data[31:24];
            2'd1:    wr_byte = r_data[23:16];
            2'd2:    wr_byte = r_data[15:8];
            default: wr_byte = r_data[7:0] | {7'd0, r_used};
        endcase
    end

    always_comb begin
        we   = 1'b0;
        widx = idx;
        wdat = wr_byte;
        if (r_clearing) begin
            we   = 1'b1;
            widx = r_clr_idx;
            wdat = 8'h00;
        end else if (r_busy && inr) begin
            case (r_op)
                MEM_WR32: we = 1'b1;
                MEM_SET: begin
                    we   = (r_k == 3'd1);
                    wdat = (r_rv ? r_q : 8'h00) | 8'h01;
                end
                MEM_CLR: begin
                    we   = (r_k == 3'd1);
                    wdat = (r_rv ? r_q : 8'h00) & 8'hfe;
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[widx] <= wdat;
        end
        r_q <= mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_k        <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_clearing) begin
                if (r_clr_idx == MEM_AW'(HEAP_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                end
            end else if (r_busy) begin
                case (r_op)
                    MEM_RD32: begin
                        if (r_k == 3'd4) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                    MEM_WR32: begin
                        if (r_k == 3'd3) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                    default: begin
                        if (r_k == 3'd1) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                endcase
            end else if (i_cmd.valid) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end
        end
    end

    // payload side of the engine
    always_ff @(posedge i_clk) begin
        r_rv <= inr;
        if (!r_busy && !r_clearing && i_cmd.valid) begin
            r_op   <= i_cmd.op;
            r_addr <= i_cmd.addr;
            r_data <= i_cmd.data;
            r_used <= i_cmd.used;
        end
        if (r_busy && r_op == MEM_RD32 && r_k != 3'd0) begin
            r_acc <= {r_acc[23:0], (r_rv ? r_q : 8'h00)};
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.clearing = r_clearing;
    assign o_sts.rdata    = r_acc;

endmodule

// ===== hdl/fla_ctrl.sv =====
// Controller: sequences allocate, free and format as tag reads and writes.
`timescale 1ns / 1ps
module fla_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  fla_pkg::t_req                   i_req,
    output logic                            o_done,
    output fla_pkg::t_rsp                   o_rsp,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fla_pkg::HSIZE_W-1:0]     i_cfg_data,
    output fla_pkg::t_mem_cmd               o_cmd,
    input  fla_pkg::t_mem_sts               i_sts
);
    import fla_pkg::*;

    localparam t_addr HEAP_A = t_addr'(HEAP_BYTES);

    function automatic t_mem_cmd mk(t_mem_op op, t_addr a, t_addr d, logic u);
        t_mem_cmd c;
        c.valid = 1'b0;
        c.op    = op;
        c.addr  = a;
        c.data  = d[31:0];
        c.used  = u;
        return c;
    endfunction

    t_state             r_state, n_state;
    logic               r_wait, n_wait;
    logic               r_init, n_init;
    logic [HSIZE_W-1:0] r_heap_size;
    logic               r_done, n_done;
    logic [1:0]         r_status, n_status;
    logic [15:0]        r_pay, n_pay;

    t_addr r_size, n_size, r_need, n_need, r_ff, n_ff, r_old, n_old;
    t_addr r_nxt, n_nxt, r_prv, n_prv, r_first, n_first, r_blk, n_blk;
    t_addr r_i, n_i, r_nb, n_nb, r_lsz, n_lsz, r_rsz, n_rsz;
    t_addr r_ns, n_ns, r_s, n_s, r_hdr, n_hdr;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic r_walked, n_walked, r_single, n_single, r_left_free, n_left_free;

    t_mem_cmd cmd;
    logic     is_cmd;
    logic     dn;
    t_addr    rd_v;
    t_addr    a_sz;
    t_addr    hs;
    t_addr    hs_cut;
    t_addr    rem;

    assign dn   = i_sts.done;
    assign rd_v = {4'b0000, i_sts.rdata};
    assign rem  = r_ff + r_need;

    always_comb begin
        a_sz = {20'd0, i_req.req_size};
        if (a_sz < 36'sd8) begin
            a_sz = 36'sd8;
        end
        if (a_sz[0]) begin
            a_sz = a_sz + 36'sd1;
        end
        hs     = r_init ? HEAP_A : t_addr'(r_heap_size);
        hs_cut = (hs > HEAP_A) ? HEAP_A : hs;
        hs_cut = {hs_cut[ADDR_W-1:1], 1'b0} - 36'sd8;
    end

    always_comb begin
        n_state = r_state;   n_init = r_init;     n_done = 1'b0;
        n_status = r_status; n_pay = r_pay;
        n_size = r_size; n_need = r_need; n_ff = r_ff; n_old = r_old;
        n_nxt = r_nxt; n_prv = r_prv; n_first = r_first; n_blk = r_blk;
        n_i = r_i; n_nb = r_nb; n_lsz = r_lsz; n_rsz = r_rsz;
        n_ns = r_ns; n_s = r_s; n_hdr = r_hdr; n_steps = r_steps;
        n_walked = r_walked; n_single = r_single; n_left_free = r_left_free;
        cmd    = mk(MEM_RD32, '0, '0, 1'b0);
        is_cmd = 1'b0;

        case (r_state)
            S_CLR: begin
                if (!i_sts.clearing) begin
                    n_state = S_FMT0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_size   = a_sz;
                    n_need   = a_sz + 36'sd8;
                    n_blk    = $signed({20'd0, i_req.free_offset}) - 36'sd4;
                    n_walked = 1'b0;
                    n_single = 1'b0;
                    case (i_req.op)
                        OP_ALLOC:  n_state = S_A_HEAD;
                        OP_FREE:   n_state = S_F_HDR;
                        OP_FORMAT: n_state = S_FMT0;
                        default: begin
                            n_done = 1'b1; n_status = ST_OK; n_pay = '0;
                        end
                    endcase
                end
            end

            // format
            S_FMT0: begin
                if (hs < 36'sd16) begin
                    n_state = S_IDLE;
                    n_done = !r_init; n_status = ST_OK; n_pay = '0;
                end else begin
                    n_s = hs_cut;
                    n_state = S_FMT1;
                end
            end
            S_FMT1: begin
                cmd = mk(MEM_WR32, 36'sd0, 36'sd4, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FMT2;
            end
            S_FMT2: begin
                cmd = mk(MEM_WR32, 36'sd4, r_s, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FMT3;
            end
            S_FMT3: begin
                cmd = mk(MEM_WR32, 36'sd8, 36'sd0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FMT4;
            end
            S_FMT4: begin
                cmd = mk(MEM_WR32, 36'sd12, 36'sd0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FMT5;
            end
            S_FMT5: begin
                cmd = mk(MEM_WR32, r_s, r_s, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FMT6;
            end
            S_FMT6: begin
                cmd = mk(MEM_WR32, r_s + 36'sd4, 36'sh01010101, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_state = S_IDLE;
                    n_done = !r_init; n_status = ST_OK; n_pay = '0;
                    n_init = 1'b0;
                end
            end

            // allocate: look at the list head first
            S_A_HEAD: begin
                cmd = mk(MEM_RD32, 36'sd0, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_ff = rd_v;
                    if (rd_v == 36'sd0) begin
                        n_state = S_IDLE; n_done = 1'b1;
                        n_status = ST_NOFIT; n_pay = '0;
                    end else begin
                        n_state = S_A_OLD;
                    end
                end
            end
            S_A_OLD: begin
                cmd = mk(MEM_RD32, r_ff, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_old = rd_v; n_state = S_A_NXT; end
            end
            S_A_NXT: begin
                cmd = mk(MEM_RD32, r_ff + 36'sd4, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_nxt = rd_v; n_state = S_A_PRV; end
            end
            S_A_PRV: begin
                cmd = mk(MEM_RD32, r_ff + 36'sd8, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_prv = rd_v;
                    if (r_nxt == 36'sd0 && rd_v == 36'sd0) begin
                        // lone free block
                        if (r_need > r_old) begin
                            n_state = S_IDLE; n_done = 1'b1;
                            n_status = ST_NOFIT; n_pay = '0;
                        end else if (r_old - r_need >= 36'sd16) begin
                            n_single = 1'b1;
                            n_state  = S_GS_HDR;
                        end else begin
                            n_state = S_GW_SET;
                        end
                    end else if (r_old < r_need) begin
                        n_i = r_ff; n_steps = '0;
                        n_state = S_W_LINK;
                    end else begin
                        n_state = S_G0;
                    end
                end
            end
            S_W_LINK: begin
                if (r_steps >= STEP_W'(HEAP_BYTES)) begin
                    n_state = S_IDLE; n_done = 1'b1;
                    n_status = ST_NOFIT; n_pay = '0;
                end else begin
                    cmd = mk(MEM_RD32, r_i + 36'sd4, '0, 1'b0); is_cmd = 1'b1;
                    if (dn) begin
                        n_steps = r_steps + 1'b1;
                        n_nb    = rd_v;
                        if (rd_v == 36'sd0) begin
                            n_state = S_IDLE; n_done = 1'b1;
                            n_status = ST_NOFIT; n_pay = '0;
                        end else begin
                            n_state = S_W_SIZE;
                        end
                    end
                end
            end
            S_W_SIZE: begin
                cmd = mk(MEM_RD32, r_nb, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_old = rd_v;
                    if (rd_v >= r_need) begin
                        n_ff = r_nb; n_walked = 1'b1; n_state = S_G_NXT;
                    end else begin
                        n_i = r_nb; n_state = S_W_LINK;
                    end
                end
            end
            S_G_NXT: begin
                cmd = mk(MEM_RD32, r_ff + 36'sd4, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_nxt = rd_v; n_state = S_G_PRV; end
            end
            S_G_PRV: begin
                cmd = mk(MEM_RD32, r_ff + 36'sd8, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_prv = rd_v; n_state = S_G0; end
            end
            S_G0: begin
                n_state = (r_old - r_need >= 36'sd16) ? S_GS_HDR : S_GW_SET;
            end

            // split: allocated front, free remainder takes the list slot
            S_GS_HDR: begin
                cmd = mk(MEM_WR32, r_ff, r_need, 1'b1); is_cmd = 1'b1;
                if (dn) n_state = S_GS_FTR;
            end
            S_GS_FTR: begin
                cmd = mk(MEM_WR32, r_ff + r_size + 36'sd4, r_need, 1'b1); is_cmd = 1'b1;
                if (dn) n_state = S_GS_RHDR;
            end
            S_GS_RHDR: begin
                cmd = mk(MEM_WR32, rem, r_old - r_need, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_GS_RNXT;
            end
            S_GS_RNXT: begin
                cmd = mk(MEM_WR32, rem + 36'sd4, r_nxt, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_GS_RPRV;
            end
            S_GS_RPRV: begin
                cmd = mk(MEM_WR32, rem + 36'sd8, r_prv, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = r_single ? S_GS_HEAD1 : S_GS_TAIL;
            end
            S_GS_HEAD1: begin
                cmd = mk(MEM_WR32, 36'sd0, rem, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_GS_TAIL;
            end
            S_GS_TAIL: begin
                cmd = mk(MEM_WR32, r_ff + r_old - 36'sd4, r_old - r_need, 1'b0);
                is_cmd = 1'b1;
                if (dn) begin
                    if (r_single) begin
                        n_state = S_IDLE; n_done = 1'b1;
                        n_status = ST_OK; n_pay = r_ff[15:0] + 16'd4;
                    end else begin
                        n_state = S_GS_NLNK;
                    end
                end
            end
            S_GS_NLNK: begin
                if (r_nxt != 36'sd0) begin
                    cmd = mk(MEM_WR32, r_nxt + 36'sd8, rem, 1'b0); is_cmd = 1'b1;
                    if (dn) n_state = S_GS_PLNK;
                end else begin
                    n_state = S_GS_PLNK;
                end
            end
            S_GS_PLNK: begin
                if (r_prv != 36'sd0 && r_walked) begin
                    cmd = mk(MEM_WR32, r_prv + 36'sd4, rem, 1'b0);
                end else begin
                    cmd = mk(MEM_WR32, 36'sd0, rem, 1'b0);
                end
                is_cmd = 1'b1;
                if (dn) begin
                    n_state = S_IDLE; n_done = 1'b1;
                    n_status = ST_OK; n_pay = r_ff[15:0] + 16'd4;
                end
            end

            // whole block: unlink and mark used
            S_GW_SET: begin
                cmd = mk(MEM_SET, r_ff + 36'sd3, '0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = r_walked ? S_GW_NLNK : S_GW_HEAD;
            end
            S_GW_HEAD: begin
                cmd = mk(MEM_WR32, 36'sd0, r_nxt, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_GW_NCLR;
            end
            S_GW_NCLR: begin
                if (r_nxt != 36'sd0) begin
                    cmd = mk(MEM_WR32, r_nxt + 36'sd8, 36'sd0, 1'b0); is_cmd = 1'b1;
                    if (dn) n_state = S_GW_SETF;
                end else begin
                    n_state = S_GW_SETF;
                end
            end
            S_GW_NLNK: begin
                if (r_nxt != 36'sd0) begin
                    cmd = mk(MEM_WR32, r_nxt + 36'sd8, r_prv, 1'b0); is_cmd = 1'b1;
                    if (dn) n_state = S_GW_PLNK;
                end else begin
                    n_state = S_GW_PLNK;
                end
            end
            S_GW_PLNK: begin
                if (r_prv != 36'sd0) begin
                    cmd = mk(MEM_WR32, r_prv + 36'sd4, r_nxt, 1'b0); is_cmd = 1'b1;
                    if (dn) n_state = S_GW_SELF;
                end else begin
                    n_state = S_GW_SELF;
                end
            end
            S_GW_SELF: begin
                if (r_nxt == r_ff) begin
                    cmd = mk(MEM_WR32, r_ff + 36'sd4, 36'sd0, 1'b0); is_cmd = 1'b1;
                    if (dn) n_state = S_GW_SETF;
                end else begin
                    n_state = S_GW_SETF;
                end
            end
            S_GW_SETF: begin
                cmd = mk(MEM_SET, r_ff + r_old - 36'sd1, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_state = S_IDLE; n_done = 1'b1;
                    n_status = ST_OK; n_pay = r_ff[15:0] + 16'd4;
                end
            end

            // free: validate tags, clear the used bit and read the list head
            S_F_HDR: begin
                if (r_blk == -36'sd4) begin
                    n_state = S_IDLE; n_done = 1'b1;
                    n_status = ST_BADFREE; n_pay = '0;
                end else begin
                    cmd = mk(MEM_RD32, r_blk, '0, 1'b0); is_cmd = 1'b1;
                    if (dn) begin
                        n_hdr = rd_v;
                        if (!rd_v[0]) begin
                            n_state = S_IDLE; n_done = 1'b1;
                            n_status = ST_BADFREE; n_pay = '0;
                        end else begin
                            n_state = S_F_FTR;
                        end
                    end
                end
            end
            S_F_FTR: begin
                cmd = mk(MEM_RD32, r_blk + r_hdr - 36'sd5, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    if (rd_v != r_hdr) begin
                        n_state = S_IDLE; n_done = 1'b1;
                        n_status = ST_BADFREE; n_pay = '0;
                    end else begin
                        n_state = S_F_CLR;
                    end
                end
            end
            S_F_CLR: begin
                cmd = mk(MEM_CLR, r_blk + 36'sd3, '0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_F_SIZE;
            end
            S_F_SIZE: begin
                cmd = mk(MEM_RD32, r_blk, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_size = rd_v; n_state = S_F_FIRST; end
            end
            S_F_FIRST: begin
                cmd = mk(MEM_RD32, 36'sd0, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_first = rd_v;
                    if (rd_v == 36'sd0) begin
                        n_state = S_FE_CLR;
                    end else if (r_blk == 36'sd4) begin
                        n_state = S_FB_RD;
                    end else begin
                        n_state = S_FL_RD;
                    end
                end
            end

            // empty list: block becomes the list
            S_FE_CLR: begin
                cmd = mk(MEM_CLR, r_blk + r_size - 36'sd1, '0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FE_HEAD;
            end
            S_FE_HEAD: begin
                cmd = mk(MEM_WR32, 36'sd0, r_blk, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FE_N;
            end
            S_FE_N: begin
                cmd = mk(MEM_WR32, r_blk + 36'sd4, 36'sd0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FE_P;
            end
            S_FE_P: begin
                cmd = mk(MEM_WR32, r_blk + 36'sd8, 36'sd0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_state = S_IDLE; n_done = 1'b1; n_status = ST_OK; n_pay = '0;
                end
            end

            // first block of the heap: no left neighbour
            S_FB_RD: begin
                cmd = mk(MEM_RD32, r_blk + r_size, '0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = rd_v[0] ? S_FB_CLR : S_MR_RSZ;
            end
            S_FB_CLR: begin
                cmd = mk(MEM_CLR, r_blk + r_size - 36'sd1, '0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FB_FL;
            end
            S_FB_FL: begin
                cmd = mk(MEM_WR32, r_first + 36'sd8, r_blk, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FB_N;
            end
            S_FB_N: begin
                cmd = mk(MEM_WR32, r_blk + 36'sd4, r_first, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FB_P;
            end
            S_FB_P: begin
                cmd = mk(MEM_WR32, r_blk + 36'sd8, 36'sd0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_FB_HEAD;
            end
            S_FB_HEAD: begin
                cmd = mk(MEM_WR32, 36'sd0, 36'sd4, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_state = S_IDLE; n_done = 1'b1; n_status = ST_OK; n_pay = '0;
                end
            end

            // neighbour tags
            S_FL_RD: begin
                cmd = mk(MEM_RD32, r_blk - 36'sd4, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_left_free = !rd_v[0]; n_state = S_FR_RD; end
            end
            S_FR_RD: begin
                cmd = mk(MEM_RD32, r_blk + r_size, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    if (rd_v[0]) begin
                        n_state = S_PH_N;
                    end else if (!r_left_free) begin
                        n_state = S_MR_CLR;
                    end else begin
                        n_state = S_B_CLR;
                    end
                end
            end

            // push on list head, no merge
            S_PH_N: begin
                cmd = mk(MEM_WR32, r_blk + 36'sd4, r_first, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_PH_FL;
            end
            S_PH_FL: begin
                cmd = mk(MEM_WR32, r_first + 36'sd8, r_blk, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_PH_P;
            end
            S_PH_P: begin
                cmd = mk(MEM_WR32, r_blk + 36'sd8, 36'sd0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_PH_HEAD;
            end
            S_PH_HEAD: begin
                cmd = mk(MEM_WR32, 36'sd0, r_blk, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_PH_CLR;
            end
            S_PH_CLR: begin
                cmd = mk(MEM_CLR, r_blk + r_size - 36'sd1, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_state = S_IDLE; n_done = 1'b1; n_status = ST_OK; n_pay = '0;
                end
            end

            // merge with right neighbour, taking over its list links
            S_MR_CLR: begin
                cmd = mk(MEM_CLR, r_blk + r_size - 36'sd1, '0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_MR_RSZ;
            end
            S_MR_RSZ: begin
                cmd = mk(MEM_RD32, r_blk + r_size, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_ns = r_size + rd_v; n_state = S_MR_NXT; end
            end
            S_MR_NXT: begin
                cmd = mk(MEM_RD32, r_blk + r_size + 36'sd4, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_nxt = rd_v; n_state = S_MR_PRV; end
            end
            S_MR_PRV: begin
                cmd = mk(MEM_RD32, r_blk + r_size + 36'sd8, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_prv = rd_v; n_state = S_MR_HDR; end
            end
            S_MR_HDR: begin
                cmd = mk(MEM_WR32, r_blk, r_ns, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_MR_N;
            end
            S_MR_N: begin
                cmd = mk(MEM_WR32, r_blk + 36'sd4, r_nxt, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_MR_NLNK;
            end
            S_MR_NLNK: begin
                if (r_nxt != 36'sd0) begin
                    cmd = mk(MEM_WR32, r_nxt + 36'sd8, r_blk, 1'b0); is_cmd = 1'b1;
                    if (dn) n_state = S_MR_P;
                end else begin
                    n_state = S_MR_P;
                end
            end
            S_MR_P: begin
                cmd = mk(MEM_WR32, r_blk + 36'sd8, r_prv, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_MR_PLNK;
            end
            S_MR_PLNK: begin
                if (r_prv != 36'sd0) begin
                    cmd = mk(MEM_WR32, r_prv + 36'sd4, r_blk, 1'b0);
                end else begin
                    cmd = mk(MEM_WR32, 36'sd0, r_blk, 1'b0);
                end
                is_cmd = 1'b1;
                if (dn) n_state = S_MR_FTR;
            end
            S_MR_FTR: begin
                cmd = mk(MEM_WR32, r_blk + r_ns - 36'sd4, r_ns, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_state = S_IDLE; n_done = 1'b1; n_status = ST_OK; n_pay = '0;
                end
            end

            // merge with both neighbours; right one leaves the list
            S_B_CLR: begin
                cmd = mk(MEM_CLR, r_blk + r_size - 36'sd1, '0, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_B_LSZ;
            end
            S_B_LSZ: begin
                cmd = mk(MEM_RD32, r_blk - 36'sd4, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_lsz = rd_v; n_state = S_B_RSZ; end
            end
            S_B_RSZ: begin
                cmd = mk(MEM_RD32, r_blk + r_size, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin
                    n_rsz = rd_v;
                    n_ns  = r_size + r_lsz + rd_v;
                    n_state = S_B_HDR;
                end
            end
            S_B_HDR: begin
                cmd = mk(MEM_WR32, r_blk - r_lsz, r_ns, 1'b0); is_cmd = 1'b1;
                if (dn) n_state = S_B_NXT;
            end
            S_B_NXT: begin
                cmd = mk(MEM_RD32, r_blk + r_size + 36'sd4, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_nxt = rd_v; n_state = S_B_PRV; end
            end
            S_B_PRV: begin
                cmd = mk(MEM_RD32, r_blk + r_size + 36'sd8, '0, 1'b0); is_cmd = 1'b1;
                if (dn) begin n_prv = rd_v; n_state = S_B_NLNK; end
            end
            S_B_NLNK: begin
                if (r_nxt != 36'sd0) begin
                    cmd = mk(MEM_WR32, r_nxt + 36'sd8, r_prv, 1'b0); is_cmd = 1'b1;
                    if (dn) n_state = S_B_PLNK;
                end else begin
                    n_state = S_B_PLNK;
                end
            end
            S_B_PLNK: begin
                if (r_prv != 36'sd0) begin
                    cmd = mk(MEM_WR32, r_prv + 36'sd4, r_nxt, 1'b0);
                end else begin
                    cmd = mk(MEM_WR32, 36'sd0, r_nxt, 1'b0);
                end
                is_cmd = 1'b1;
                if (dn) n_state = S_B_FTR;
            end
            S_B_FTR: begin
                cmd = mk(MEM_WR32, r_blk + r_size + r_rsz - 36'sd4, r_ns, 1'b0);
                is_cmd = 1'b1;
                if (dn) begin
                    n_state = S_IDLE; n_done = 1'b1; n_status = ST_OK; n_pay = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // one request to the engine per command state, then wait for done
        n_wait = is_cmd && !dn;
    end

    always_comb begin
        o_cmd       = cmd;
        o_cmd.valid = is_cmd && !r_wait;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_wait      <= 1'b0;
            r_init      <= 1'b1;
            r_done      <= 1'b0;
            r_heap_size <= HSIZE_RESET;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_init  <= n_init;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                r_heap_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status; r_pay <= n_pay;
        r_size <= n_size; r_need <= n_need; r_ff <= n_ff; r_old <= n_old;
        r_nxt <= n_nxt; r_prv <= n_prv; r_first <= n_first; r_blk <= n_blk;
        r_i <= n_i; r_nb <= n_nb; r_lsz <= n_lsz; r_rsz <= n_rsz;
        r_ns <= n_ns; r_s <= n_s; r_hdr <= n_hdr; r_steps <= n_steps;
        r_walked <= n_walked; r_single <= n_single; r_left_free <= n_left_free;
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_done               = r_done;
    assign o_rsp.status         = r_status;
    assign o_rsp.payload_offset = r_pay;
    assign o_cfg_ready          = 1'b1;

endmodule
